@@ sv/tbc_pkg.sv @@
// Package: types and codes shared by the ttl buffer cache modules.
package tbc_pkg;

    localparam logic [1:0] MODE_REQ  = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_INIT = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;

    localparam logic [2:0] REG_SHORT_N    = 3'd0;
    localparam logic [2:0] REG_LONG_N     = 3'd1;
    localparam logic [2:0] REG_SHORT_BUF  = 3'd2;
    localparam logic [2:0] REG_LONG_BUF   = 3'd3;
    localparam logic [2:0] REG_SHORT_LIFE = 3'd4;
    localparam logic [2:0] REG_LONG_LIFE  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RST_CLR,
        S_INIT,
        S_TICK_RD,
        S_TICK_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HINT_CHK,
        S_UNQ_RD,
        S_UNQ_WR,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_DONE
    } state_t;

endpackage

@@ sv/ttl_buffer_cache_core.sv @@
// Top level: two-pool TTL fetch buffer cache with a sequenced shared datapath.
//
// Usage: pulse start with mode and request fields while busy is low. Mode
// request returns exactly one result on the strobe result_valid for a single
// cycle; tick and init return nothing. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Sequencing: a short-pool request checks the hinted entry; a long-pool
// request walks the long pool, each entry taking one registered read of the
// entry RAMs and one covers check in the shared subtract/compare unit. A
// tick walks the entries of both pools; an init walks all 256 ring slots,
// writing the MAX_ENTRIES entries and filling both rings on the way. The
// entry and ring RAMs each have a single port.
// Reset: a clearing pass over all MAX_ENTRIES entries writes the entry RAMs
// to their reset values; busy stays high meanwhile. Results cannot be stalled:
// the receiver takes each one in its strobe cycle.
module ttl_buffer_cache_core #(
    parameter int MAX_ENTRIES = 128,
    parameter int ADDR_BITS   = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic [ADDR_BITS-1:0]  dev_addr,
    input  logic [11:0]           req_bytes,
    input  logic                  long_lived,
    input  logic [6:0]            hint_index,
    output logic                  result_valid,
    output logic [1:0]            status,
    output logic [6:0]            entry_index,
    output logic [11:0]           byte_offset,
    output logic [ADDR_BITS-1:0]  fetch_addr,
    output logic [11:0]           fetch_bytes,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [11:0]           cfg_data
);
    import tbc_pkg::*;

    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = EW + 1;

    // config
    logic [7:0]  short_n_reg, long_n_reg;
    logic [11:0] short_buf_reg, long_buf_reg;
    logic [5:0]  short_life_reg, long_life_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_n_reg    <= 8'd48;
            long_n_reg     <= 8'd16;
            short_buf_reg  <= 12'd1296;
            long_buf_reg   <= 12'd1440;
            short_life_reg <= 6'd2;
            long_life_reg  <= 6'd60;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_N:    short_n_reg    <= cfg_data[7:0];
                REG_LONG_N:     long_n_reg     <= cfg_data[7:0];
                REG_SHORT_BUF:  short_buf_reg  <= cfg_data;
                REG_LONG_BUF:   long_buf_reg   <= cfg_data;
                REG_SHORT_LIFE: short_life_reg <= cfg_data[5:0];
                REG_LONG_LIFE:  long_life_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [8:0] n_s, n_t, sum_st;
    assign n_s    = (short_n_reg < 8'(MAX_ENTRIES)) ? {1'b0, short_n_reg}
                                                    : 9'(MAX_ENTRIES);
    assign sum_st = n_s + {1'b0, long_n_reg};
    assign n_t    = (sum_st < 9'(MAX_ENTRIES)) ? sum_st : 9'(MAX_ENTRIES);

    logic [5:0] s_life, l_life;
    assign s_life = (short_life_reg == 6'd0) ? 6'd1 : short_life_reg;
    assign l_life = (long_life_reg == 6'd0) ? 6'd1 : long_life_reg;

    // request latch
    logic [ADDR_BITS-1:0] addr_reg;
    logic [11:0]          bytes_reg;
    logic                 want_long_reg;
    logic [6:0]           hint_reg;

    // ring pointers
    logic [7:0] sh_head_reg, sh_tail_reg, lg_head_reg, lg_tail_reg;
    logic [7:0] sh_head_next, sh_tail_next, lg_head_next, lg_tail_next;

    state_t state_reg, state_next;
    logic [8:0] cnt_reg, cnt_next;       // entry / slot walker
    logic [EW-1:0] idx_reg, idx_next;    // entry under work
    logic [7:0] pos_reg, pos_next;       // queue position of entry under work
    logic       pool_long_reg, pool_long_next;

    // RAM ports
    logic [EW-1:0] e_addr;
    logic [ADDR_BITS-1:0] src_w, src_r;
    logic [5:0]    life_w, life_r;
    logic [7:0]    qp_w, qp_r;
    logic          src_we, life_we, qp_we;
    logic          sr_we, lr_we;
    logic [7:0]    sr_addr, lr_addr;
    logic [6:0]    ring_w, sr_r, lr_r;

    tbc_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_ENTRIES)) u_src
        (.clk(clk), .we(src_we), .addr(e_addr), .wdata(src_w), .rdata(src_r));
    tbc_ram #(.WIDTH(6), .DEPTH(MAX_ENTRIES)) u_life
        (.clk(clk), .we(life_we), .addr(e_addr), .wdata(life_w), .rdata(life_r));
    tbc_ram #(.WIDTH(8), .DEPTH(MAX_ENTRIES)) u_qpos
        (.clk(clk), .we(qp_we), .addr(e_addr), .wdata(qp_w), .rdata(qp_r));
    tbc_ram #(.WIDTH(7), .DEPTH(256)) u_sring
        (.clk(clk), .we(sr_we), .addr(sr_addr), .wdata(ring_w), .rdata(sr_r));
    tbc_ram #(.WIDTH(7), .DEPTH(256)) u_lring
        (.clk(clk), .we(lr_we), .addr(lr_addr), .wdata(ring_w), .rdata(lr_r));

    // shared subtract / compare unit
    logic [ADDR_BITS:0] diff;
    logic        covers;
    logic        idx_is_long;
    logic [11:0] idx_buf;
    assign idx_is_long = ({2'b0, idx_reg} >= (EW+2)'(n_s))
                         && ({2'b0, idx_reg} < (EW+2)'(n_t));
    assign idx_buf = idx_is_long ? long_buf_reg : short_buf_reg;
    assign diff    = {1'b0, addr_reg} - {1'b0, src_r};
    assign covers  = !diff[ADDR_BITS]
                     && ((diff[ADDR_BITS-1:0] >> 12) == '0)
                     && ({1'b0, diff[11:0]} + {1'b0, bytes_reg} <= {1'b0, idx_buf});

    logic [ADDR_BITS-1:0] fetch_al;
    assign fetch_al = {addr_reg[ADDR_BITS-1:4], 4'b0};

    // output regs
    logic res_v_reg, res_v_next;
    logic [1:0] status_reg, status_next;
    logic [6:0] eidx_reg, eidx_next;
    logic [11:0] boff_reg, boff_next;
    logic [ADDR_BITS-1:0] fa_reg, fa_next;
    logic [11:0] fb_reg, fb_next;
    logic unq_moved_reg, unq_moved_next;   // second write of unqueue pending
    logic [6:0] moved_reg, moved_next;
    logic do_hit_reg, do_hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_CLR;
            cnt_reg       <= '0;
            sh_head_reg   <= '0;
            sh_tail_reg   <= '0;
            lg_head_reg   <= '0;
            lg_tail_reg   <= '0;
            res_v_reg     <= 1'b0;
            unq_moved_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sh_head_reg   <= sh_head_next;
            sh_tail_reg   <= sh_tail_next;
            lg_head_reg   <= lg_head_next;
            lg_tail_reg   <= lg_tail_next;
            res_v_reg     <= res_v_next;
            unq_moved_reg <= unq_moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        pool_long_reg <= pool_long_next;
        status_reg    <= status_next;
        eidx_reg      <= eidx_next;
        boff_reg      <= boff_next;
        fa_reg        <= fa_next;
        fb_reg        <= fb_next;
        moved_reg     <= moved_next;
        do_hit_reg    <= do_hit_next;
        if (start && !busy)
        begin
            addr_reg      <= dev_addr;
            bytes_reg     <= req_bytes;
            want_long_reg <= long_lived;
            hint_reg      <= hint_index;
        end
    end

    assign busy = (state_reg != S_IDLE);
    logic accept;
    assign accept = start && !busy;

    // pool-relative reset position of an entry
    logic [7:0] home_pos;
    assign home_pos = (({1'b0, cnt_reg[7:0]} >= n_s) && ({1'b0, cnt_reg[7:0]} < n_t))
                      ? 8'(cnt_reg[7:0] - n_s[7:0]) : cnt_reg[7:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority case (1'b1)
                        mode == MODE_TICK: state_next = (n_t == 9'd0) ? S_IDLE : S_TICK_RD;
                        mode == MODE_INIT: state_next = S_INIT;
                        mode == MODE_REQ:
                            state_next = (long_lived || ({2'b0, hint_index} >= n_s))
                                         ? S_SCAN_RD : S_HINT_CHK;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RST_CLR:  state_next = (cnt_reg == 9'(MAX_ENTRIES-1)) ? S_IDLE : S_RST_CLR;
            S_INIT:     state_next = (cnt_reg == 9'd255) ? S_IDLE : S_INIT;
            S_TICK_RD:  state_next = S_TICK_WR;
            S_TICK_WR:  state_next = (cnt_reg + 9'd1 >= n_t) ? S_IDLE : S_TICK_RD;
            S_SCAN_RD:  state_next = (cnt_reg >= n_t) ? S_ALLOC_RD : S_SCAN_CHK;
            S_SCAN_CHK: state_next = covers ? S_UNQ_RD : S_SCAN_RD;
            S_HINT_CHK: state_next = (cnt_reg[0] == 1'b0) ? S_HINT_CHK
                                     : (covers ? S_UNQ_RD : S_ALLOC_RD);
            S_UNQ_RD:   state_next = S_UNQ_WR;
            S_UNQ_WR:   state_next = unq_moved_next ? S_UNQ_WR : S_DONE;
            S_ALLOC_RD: state_next = res_v_next ? S_DONE : S_ALLOC_WR;
            S_ALLOC_WR: state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath / outputs
    always_comb
    begin
        logic [7:0] tl, hd;
        logic       q_nonempty;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        pool_long_next = pool_long_reg;
        sh_head_next   = sh_head_reg;
        sh_tail_next   = sh_tail_reg;
        lg_head_next   = lg_head_reg;
        lg_tail_next   = lg_tail_reg;
        res_v_next     = 1'b0;
        status_next    = status_reg;
        eidx_next      = eidx_reg;
        boff_next      = boff_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        unq_moved_next = 1'b0;
        moved_next     = moved_reg;
        do_hit_next    = do_hit_reg;
        e_addr  = idx_reg;
        src_we  = 1'b0;  src_w  = '0;
        life_we = 1'b0;  life_w = '0;
        qp_we   = 1'b0;  qp_w   = '0;
        sr_we   = 1'b0;  sr_addr = sh_tail_reg;
        lr_we   = 1'b0;  lr_addr = lg_tail_reg;
        ring_w  = '0;
        tl = pool_long_reg ? lg_tail_reg : sh_tail_reg;
        hd = pool_long_reg ? lg_head_reg : sh_head_reg;
        q_nonempty = (tl != hd);

        unique case (state_reg)
            S_IDLE:
            begin
                // tick and init walk from entry zero
                cnt_next = '0;
                if (accept && mode == MODE_REQ)
                begin
                    if (!(long_lived || ({2'b0, hint_index} >= n_s)))
                    begin
                        idx_next       = EW'(hint_index);
                        pool_long_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next       = n_s;
                        pool_long_next = 1'b1;
                    end
                end
            end
            S_RST_CLR:
            begin
                e_addr  = cnt_reg[EW-1:0];
                src_we  = 1'b1;
                life_we = 1'b1;
                qp_we   = 1'b1;
                qp_w    = home_pos;
                cnt_next = cnt_reg + 9'd1;
            end
            S_INIT:
            begin
                // one slot of each ring and one entry per cycle
                e_addr  = cnt_reg[EW-1:0];
                sr_addr = cnt_reg[7:0];
                lr_addr = 8'(cnt_reg[7:0] - n_s[7:0]);
                if (cnt_reg < 9'(MAX_ENTRIES))
                begin
                    src_we  = 1'b1;
                    life_we = 1'b1;
                    qp_we   = 1'b1;
                    qp_w    = (cnt_reg < n_t) ? home_pos : 8'd0;
                end
                sr_we  = (cnt_reg < n_s);
                lr_we  = (cnt_reg >= n_s) && (cnt_reg < n_t);
                ring_w = cnt_reg[6:0];
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd255)
                begin
                    sh_tail_next = '0;
                    lg_tail_next = '0;
                    sh_head_next = n_s[7:0];
                    lg_head_next = 8'(n_t - n_s);
                end
            end
            S_TICK_RD:
            begin
                e_addr   = cnt_reg[EW-1:0];
                idx_next = cnt_reg[EW-1:0];
            end
            S_TICK_WR:
            begin
                e_addr = idx_reg;
                if (life_r != 6'd0)
                begin
                    life_we = 1'b1;
                    life_w  = life_r - 6'd1;
                    if (life_r == 6'd1)
                    begin
                        qp_we  = 1'b1;
                        ring_w = 7'(idx_reg);
                        if (cnt_reg < n_s)
                        begin
                            qp_w         = sh_head_reg;
                            sr_addr      = sh_head_reg;
                            sr_we        = 1'b1;
                            sh_head_next = sh_head_reg + 8'd1;
                        end
                        else
                        begin
                            qp_w         = lg_head_reg;
                            lr_addr      = lg_head_reg;
                            lr_we        = 1'b1;
                            lg_head_next = lg_head_reg + 8'd1;
                        end
                    end
                end
                cnt_next = cnt_reg + 9'd1;
            end
            S_SCAN_RD:
            begin
                e_addr   = cnt_reg[EW-1:0];
                idx_next = cnt_reg[EW-1:0];
                cnt_next = cnt_reg + 9'd1;
                pool_long_next = 1'b1;
            end
            S_SCAN_CHK, S_HINT_CHK:
            begin
                // hint path waits for the registered read before it checks
                if (state_reg == S_HINT_CHK && cnt_reg[0] == 1'b0)
                    cnt_next = 9'd1;
                else if (covers)
                begin
                    status_next = ST_HIT;
                    eidx_next   = 7'(idx_reg);
                    boff_next   = diff[11:0];
                    fa_next     = '0;
                    fb_next     = '0;
                end
            end
            S_UNQ_RD:
            begin
                // life_r, qp_r valid; read ring slot at tail
                sr_addr = sh_tail_reg;
                lr_addr = lg_tail_reg;
                pos_next   = qp_r;
                do_hit_next = (life_r == 6'd0) && q_nonempty;
                life_we = 1'b1;
                life_w  = pool_long_reg ? l_life : s_life;
            end
            S_UNQ_WR:
            begin
                if (!unq_moved_reg)
                begin
                    moved_next = pool_long_reg ? lr_r : sr_r;
                    if (do_hit_reg)
                    begin
                        if (pos_reg != tl)
                        begin
                            ring_w  = pool_long_reg ? lr_r : sr_r;
                            sr_addr = pos_reg;
                            lr_addr = pos_reg;
                            sr_we   = !pool_long_reg;
                            lr_we   = pool_long_reg;
                            unq_moved_next = 1'b1;
                        end
                        if (pool_long_reg) lg_tail_next = lg_tail_reg + 8'd1;
                        else               sh_tail_next = sh_tail_reg + 8'd1;
                    end
                end
                else
                begin
                    e_addr = ({1'b0, moved_reg} < 8'(MAX_ENTRIES)) ? EW'(moved_reg) : '0;
                    qp_we  = 1'b1;
                    qp_w   = pos_reg;
                end
                res_v_next = !unq_moved_reg && !(do_hit_reg && pos_reg != tl);
                if (unq_moved_reg) res_v_next = 1'b1;
            end
            S_ALLOC_RD:
            begin
                // ring read data at tail is valid now
                if (want_long_reg && lg_tail_reg != lg_head_reg)
                begin
                    idx_next = ({1'b0, lr_r} < 8'(MAX_ENTRIES)) ? EW'(lr_r) : '0;
                    lg_tail_next = lg_tail_reg + 8'd1;
                end
                else if (sh_tail_reg != sh_head_reg)
                begin
                    idx_next = ({1'b0, sr_r} < 8'(MAX_ENTRIES)) ? EW'(sr_r) : '0;
                    sh_tail_next = sh_tail_reg + 8'd1;
                end
                else
                begin
                    res_v_next  = 1'b1;
                    status_next = ST_NOFREE;
                    eidx_next   = '0;
                    boff_next   = '0;
                    fa_next     = '0;
                    fb_next     = '0;
                end
            end
            S_ALLOC_WR:
            begin
                e_addr  = idx_reg;
                life_we = 1'b1;
                life_w  = s_life;
                src_we  = 1'b1;
                src_w   = fetch_al;
                res_v_next  = 1'b1;
                status_next = ST_MISS;
                eidx_next   = 7'(idx_reg);
                boff_next   = {8'd0, addr_reg[3:0]};
                fa_next     = fetch_al;
                fb_next     = idx_buf;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign result_valid = res_v_reg;
    assign status       = status_reg;
    assign entry_index  = eidx_reg;
    assign byte_offset  = boff_reg;
    assign fetch_addr   = fa_reg;
    assign fetch_bytes  = fb_reg;

`ifndef SYNTH
    a_res_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a busy window");
    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_NOFREE) |-> (fetch_bytes == 12'd0 && entry_index == 7'd0))
        else $error("no-free result not zeroed");
    a_hit_nofetch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_HIT) |-> (fetch_addr == '0 && fetch_bytes == 12'd0))
        else $error("hit carries a fetch");
    a_miss_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_MISS) |-> (fetch_addr[3:0] == 4'd0))
        else $error("fetch not aligned");
`endif
endmodule

@@ sv/tbc_ram.sv @@
// Generic single-port RAM with registered read.
module tbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ dv/ttl_buffer_cache_core_tb.sv @@
// Testbench: random and directed requests, ticks and inits against a local cache predictor.
module ttl_buffer_cache_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tbc_pkg::*;

    localparam int NENT     = 128;
    localparam int WD_LIMIT = 5000;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] addr;
        logic [11:0] nbytes;
        logic        lng;
        logic [6:0]  hint;
        int          gap;
    } req_t;

    typedef struct {
        logic [1:0]  status;
        logic [6:0]  index;
        logic [11:0] offset;
        logic [31:0] faddr;
        logic [11:0] fbytes;
    } lookup_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = MODE_TICK;
    logic [31:0] dev_addr = '0;
    logic [11:0] req_bytes = '0;
    logic        long_lived = 1'b0;
    logic [6:0]  hint_index = '0;
    logic        result_valid;
    logic [1:0]  status;
    logic [6:0]  entry_index;
    logic [11:0] byte_offset;
    logic [31:0] fetch_addr;
    logic [11:0] fetch_bytes;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    ttl_buffer_cache_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .dev_addr(dev_addr), .req_bytes(req_bytes), .long_lived(long_lived),
        .hint_index(hint_index), .result_valid(result_valid), .status(status),
        .entry_index(entry_index), .byte_offset(byte_offset),
        .fetch_addr(fetch_addr), .fetch_bytes(fetch_bytes),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // cache image
    logic [7:0]  short_n, long_n;
    logic [11:0] short_buf, long_buf;
    logic [5:0]  short_ttl, long_ttl;
    logic [31:0] src_addr[NENT];
    logic [5:0]  ttl[NENT];
    logic [7:0]  qpos[NENT];
    logic [7:0]  short_ring[256];
    logic [7:0]  long_ring[256];
    logic [7:0]  sq_head, sq_tail, lq_head, lq_tail;

    req_t    pending[$];
    lookup_t expected_lookups[$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      took = 0;
    logic [6:0] last_entry = '0;
    logic [31:0] bases[8];
    bit      burst = 0;

    function automatic int n_short();
        return short_n < NENT ? int'(short_n) : NENT;
    endfunction

    function automatic int n_total();
        int t;
        t = n_short() + int'(long_n);
        return t < NENT ? t : NENT;
    endfunction

    function automatic logic [11:0] entry_buf(int i);
        return (i >= n_short() && i < n_total()) ? long_buf : short_buf;
    endfunction

    function automatic logic [5:0] ttl_of(logic [5:0] v);
        return v == 0 ? 6'd1 : v;
    endfunction

    function automatic bit covers(int i, logic [31:0] a, logic [11:0] nb);
        longint d;
        if (a < src_addr[i])
            return 0;
        d = longint'(a) - longint'(src_addr[i]) + longint'(nb);
        return d <= longint'(entry_buf(i));
    endfunction

    function automatic int idx_ok(logic [7:0] v);
        return v < NENT ? int'(v) : 0;
    endfunction

    // swap entry with the queue tail and pop it
    task automatic take_out(int i, bit lp);
        logic [7:0] p;
        logic [7:0] moved;
        if (ttl[i] != 0)
            return;
        p = qpos[i];
        if (lp)
        begin
            if (lq_tail == lq_head)
                return;
            if (p != lq_tail)
            begin
                moved = long_ring[lq_tail];
                long_ring[p] = moved;
                qpos[idx_ok(moved)] = p;
            end
            lq_tail++;
        end
        else
        begin
            if (sq_tail == sq_head)
                return;
            if (p != sq_tail)
            begin
                moved = short_ring[sq_tail];
                short_ring[p] = moved;
                qpos[idx_ok(moved)] = p;
            end
            sq_tail++;
        end
    endtask

    task automatic cache_reset();
        short_n = 48; long_n = 16; short_buf = 1296; long_buf = 1440;
        short_ttl = 2; long_ttl = 60;
        for (int i = 0; i < NENT; i++)
        begin
            src_addr[i] = '0;
            ttl[i] = '0;
            qpos[i] = (i >= n_short() && i < n_total()) ? 8'(i - n_short()) : 8'(i);
        end
        for (int i = 0; i < 256; i++)
        begin
            short_ring[i] = '0;
            long_ring[i] = '0;
        end
        sq_head = 0; sq_tail = 0; lq_head = 0; lq_tail = 0;
    endtask

    task automatic rebuild_queues();
        int s;
        int t;
        s = n_short();
        t = n_total();
        for (int i = 0; i < 256; i++)
        begin
            short_ring[i] = '0;
            long_ring[i] = '0;
        end
        for (int i = 0; i < NENT; i++)
        begin
            src_addr[i] = '0;
            ttl[i] = '0;
            qpos[i] = '0;
        end
        for (int i = 0; i < s; i++)
        begin
            short_ring[i] = 8'(i);
            qpos[i] = 8'(i);
        end
        for (int i = s; i < t; i++)
        begin
            long_ring[i - s] = 8'(i);
            qpos[i] = 8'(i - s);
        end
        sq_tail = 0; sq_head = 8'(s);
        lq_tail = 0; lq_head = 8'(t - s);
    endtask

    task automatic age_entries();
        int s;
        int t;
        s = n_short();
        t = n_total();
        for (int i = 0; i < t; i++)
        begin
            if (ttl[i] != 0)
            begin
                ttl[i]--;
                if (ttl[i] == 0)
                begin
                    if (i < s)
                    begin
                        qpos[i] = sq_head;
                        short_ring[sq_head] = 8'(i);
                        sq_head++;
                    end
                    else
                    begin
                        qpos[i] = lq_head;
                        long_ring[lq_head] = 8'(i);
                        lq_head++;
                    end
                end
            end
        end
    endtask

    task automatic lookup(logic [31:0] a, logic [11:0] nb, logic lng, logic [6:0] hint);
        int s;
        int t;
        int idx;
        bit got;
        lookup_t r;
        logic [31:0] f;
        s = n_short();
        t = n_total();
        idx = 0;
        got = 0;
        if (lng || hint >= s)
        begin
            for (int i = s; i < t; i++)
            begin
                if (covers(i, a, nb))
                begin
                    take_out(i, 1);
                    ttl[i] = ttl_of(long_ttl);
                    r = '{ST_HIT, 7'(i), 12'(a - src_addr[i]), '0, '0};
                    expected_lookups.push_back(r);
                    return;
                end
            end
            if (lng && lq_tail != lq_head)
            begin
                idx = idx_ok(long_ring[lq_tail]);
                lq_tail++;
                got = 1;
            end
        end
        else if (covers(hint, a, nb))
        begin
            take_out(hint, 0);
            ttl[hint] = ttl_of(short_ttl);
            r = '{ST_HIT, hint, 12'(a - src_addr[hint]), '0, '0};
            expected_lookups.push_back(r);
            return;
        end
        if (!got)
        begin
            if (sq_tail == sq_head)
            begin
                r = '{ST_NOFREE, '0, '0, '0, '0};
                expected_lookups.push_back(r);
                return;
            end
            idx = idx_ok(short_ring[sq_tail]);
            sq_tail++;
        end
        f = a & ~32'hF;
        ttl[idx] = ttl_of(short_ttl);
        src_addr[idx] = f;
        r = '{ST_MISS, 7'(idx), 12'(a - f), f, entry_buf(idx)};
        expected_lookups.push_back(r);
    endtask

    // monitor: accepts requests, config writes and results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (result_valid)
            begin
                lookup_t e;
                idle_cycles = 0;
                if (expected_lookups.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d", $time, status);
                    errors++;
                end
                else
                begin
                    e = expected_lookups.pop_front();
                    if (status !== e.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, status);
                        errors++;
                    end
                    if (entry_index !== e.index)
                    begin
                        $display("%0t: entry_index exp %0d got %0d", $time, e.index,
                                 entry_index);
                        errors++;
                    end
                    if (byte_offset !== e.offset)
                    begin
                        $display("%0t: byte_offset exp %0d got %0d", $time, e.offset,
                                 byte_offset);
                        errors++;
                    end
                    if (fetch_addr !== e.faddr)
                    begin
                        $display("%0t: fetch_addr exp %h got %h", $time, e.faddr, fetch_addr);
                        errors++;
                    end
                    if (fetch_bytes !== e.fbytes)
                    begin
                        $display("%0t: fetch_bytes exp %0d got %0d", $time, e.fbytes,
                                 fetch_bytes);
                        errors++;
                    end
                    last_entry = entry_index;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHORT_N:    short_n = cfg_data[7:0];
                    REG_LONG_N:     long_n = cfg_data[7:0];
                    REG_SHORT_BUF:  short_buf = cfg_data;
                    REG_LONG_BUF:   long_buf = cfg_data;
                    REG_SHORT_LIFE: short_ttl = cfg_data[5:0];
                    REG_LONG_LIFE:  long_ttl = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                idle_cycles = 0;
                took = 1;
                case (mode)
                    MODE_REQ:  lookup(dev_addr, req_bytes, long_lived, hint_index);
                    MODE_TICK: age_entries();
                    MODE_INIT: rebuild_queues();
                    default: ;
                endcase
            end
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic s_n;
        req_t h;
        s_n = start;
        if (took)
        begin
            took = 0;
            s_n = 0;
        end
        if (!s_n && rst_n && pending.size() > 0)
        begin
            h = pending[0];
            if (h.gap > 0)
            begin
                h.gap--;
                pending[0] = h;
            end
            else
            begin
                void'(pending.pop_front());
                s_n = 1;
                mode <= h.mode;
                dev_addr <= h.addr;
                req_bytes <= h.nbytes;
                long_lived <= h.lng;
                hint_index <= h.hint;
            end
        end
        start <= s_n;
    end

    task automatic push(logic [1:0] m, logic [31:0] a, logic [11:0] nb, logic lng,
                        logic [6:0] hint, int gap);
        req_t r;
        r = '{m, a, nb, lng, hint, gap};
        while (pending.size() > 1)
            @(negedge clk);
        pending.push_back(r);
    endtask

    task automatic drain();
        while (pending.size() != 0 || start || expected_lookups.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [11:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        logic [1:0]  m;
        logic [31:0] a;
        logic [11:0] nb;
        logic [6:0]  hint;
        int k;
        k = $urandom_range(0, 99);
        m = k < 70 ? MODE_REQ : k < 90 ? MODE_TICK : k < 97 ? MODE_INIT : MODE_NONE;
        a = $urandom_range(0, 3) == 0 ? 32'($urandom)
                                      : bases[$urandom_range(0, 7)] + $urandom_range(0, 1500);
        nb = $urandom_range(0, 4) == 0 ? 12'($urandom) : 12'($urandom_range(0, 300));
        hint = $urandom_range(0, 1) ? last_entry : 7'($urandom);
        push(m, a, nb, 1'($urandom), hint, burst ? 0 : $urandom_range(0, 10));
    endtask

    initial
    begin
        logic [11:0] vals[6];
        cache_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: hits on never-fetched entries, empty-queue cases before any init, then more after it
        push(MODE_REQ, 32'h0, 12'h0, 1'b0, 7'd0, 0);
        push(MODE_REQ, 32'h0, 12'd16, 1'b1, 7'd0, 0);
        push(MODE_REQ, 32'd5000, 12'd10, 1'b0, 7'd3, 0);
        push(MODE_REQ, 32'd5000, 12'd10, 1'b1, 7'd3, 2);
        push(MODE_NONE, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 7'd127, 0);
        push(MODE_TICK, '0, '0, 1'b0, '0, 0);
        push(MODE_INIT, '0, '0, 1'b0, '0, 1);
        push(MODE_REQ, 32'h1234_5677, 12'd8, 1'b0, 7'd0, 0);
        push(MODE_REQ, 32'h1234_5680, 12'd100, 1'b0, 7'd0, 0);
        push(MODE_REQ, 32'hFFFF_FFFF, 12'hFFF, 1'b1, 7'd127, 0);
        push(MODE_REQ, 32'hFFFF_FFF0, 12'd1, 1'b1, 7'd127, 0);
        push(MODE_REQ, 32'hFFFF_FFF0, 12'd1, 1'b0, 7'd127, 0);
        push(MODE_REQ, 32'h0000_4000, 12'hFFF, 1'b0, 7'd10, 0);
        push(MODE_TICK, '0, '0, 1'b0, '0, 0);
        push(MODE_TICK, '0, '0, 1'b0, '0, 0);
        push(MODE_REQ, 32'h1234_5690, 12'd4, 1'b0, 7'd0, 0);
        push(MODE_REQ, 32'hFFFF_FFF4, 12'd2, 1'b1, 7'd0, 0);
        push(MODE_REQ, 32'h8000_0000, 12'd0, 1'b1, 7'd64, 3);
        drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0: vals = '{12'd0, 12'd0, 12'd16, 12'd16, 12'd0, 12'd0};
                1: vals = '{12'd128, 12'd128, 12'd4095, 12'd4095, 12'd63, 12'd63};
                2: vals = '{12'hFFF, 12'hFFF, 12'd16, 12'd4095, 12'd1, 12'd1};
                3: vals = '{12'd4, 12'd3, 12'd64, 12'd32, 12'd3, 12'd5};
                4: vals = '{12'd0, 12'd128, 12'd2000, 12'd100, 12'd2, 12'd63};
                default: vals = '{12'($urandom_range(0, 140)), 12'($urandom_range(0, 140)),
                                  12'($urandom_range(16, 4095)), 12'($urandom_range(16, 4095)),
                                  12'($urandom_range(0, 63)), 12'($urandom_range(0, 63))};
            endcase
            for (int r = 0; r < 6; r++)
                reg_write(3'(r), vals[r]);
            reg_write(3'($urandom_range(6, 7)), 12'($urandom));
            for (int b = 0; b < 8; b++)
                bases[b] = b == 7 ? 32'hFFFF_F000 + $urandom_range(0, 4000) : 32'($urandom);
            if ($urandom_range(0, 4) != 0)
                push(MODE_INIT, '0, '0, 1'b0, '0, 0);
            for (int n = 0; n < 128; n++)
            begin
                if (n % 32 == 0)
                    burst = $urandom_range(0, 2) == 0;
                random_item();
            end
            burst = 0;
            drain();
        end

        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
